FILE: rtl/ibqm_pkg.sv
`timescale 1ns / 1ps
package ibqm_pkg;

  localparam int PARAM_FRAC = 28;
  localparam int DIV_STEPS = 31;

  localparam logic [7:0] CFG_MAX_ITER = 8'd0;
  localparam logic [7:0] CFG_TOLERANCE = 8'd1;

  localparam logic [7:0] MAX_ITER_RESET = 8'd100;
  localparam logic [31:0] TOLERANCE_RESET = 32'd1;

  typedef struct packed {
    logic signed [31:0] corner0_x;
    logic signed [31:0] corner0_y;
    logic signed [31:0] corner1_x;
    logic signed [31:0] corner1_y;
    logic signed [31:0] corner2_x;
    logic signed [31:0] corner2_y;
    logic signed [31:0] corner3_x;
    logic signed [31:0] corner3_y;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
  } ibqm_query_t;

  typedef struct packed {
    logic signed [31:0] param_u;
    logic signed [31:0] param_v;
    logic               converged;
    logic               singular;
    logic [7:0]         iterations_used;
  } ibqm_result_t;

  // Operand pair presented to the shared multiplier.
  typedef enum logic [3:0] {
    MUL_NONE, MUL_A1_B2, MUL_A2_B1, MUL_A3_UV, MUL_B3_UV, MUL_B2_RX, MUL_A2_RY,
    MUL_A1_RY, MUL_B1_RX, MUL_U_V, MUL_A1_U, MUL_B1_U, MUL_A2_V, MUL_B2_V,
    MUL_DX_DX, MUL_DY_DY
  } mul_sel_t;

  // Destination of the product registered in the previous cycle.
  typedef enum logic [3:0] {
    WB_NONE, WB_DET_LD, WB_DET_SUB, WB_RX, WB_RY, WB_NUMU_LD, WB_NUMU_SUB,
    WB_NUMV_LD, WB_NUMV_SUB, WB_UV, WB_DX_SUB, WB_DY_SUB, WB_RES_LD, WB_RES_ADD
  } wb_sel_t;

  typedef struct packed {
    logic     load;
    logic     out_load;
    logic     div_start;
    mul_sel_t mul_sel;
    wb_sel_t  wb_sel;
  } ibqm_cmd_t;

  typedef struct packed {
    logic det_zero;
    logic below_tol;
    logic div_done;
  } ibqm_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [37:0] x);
    if (x > 38'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -38'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

endpackage

FILE: rtl/ibqm_if.sv
`timescale 1ns / 1ps
interface ibqm_query_if import ibqm_pkg::*; ();
  logic        valid;
  logic        ready;
  ibqm_query_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ibqm_result_if import ibqm_pkg::*; ();
  logic         valid;
  logic         ready;
  ibqm_result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ibqm_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/ibqm_div.sv
`timescale 1ns / 1ps
module ibqm_div import ibqm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num0,
  input  logic signed [63:0] num1,
  input  logic signed [63:0] den,
  output logic               done,
  output logic signed [31:0] quo0,
  output logic signed [31:0] quo1
);

  // Two restoring lanes share the divisor; one quotient bit per cycle each.
  logic        busy;
  logic [4:0]  count;
  logic [63:0] dmag;
  logic [63:0] rem [2];
  logic [30:0] q [2];
  logic [2:0]  nlow [2];
  logic        ovf [2];
  logic        neg [2];
  logic [63:0] nmag [2];
  logic [64:0] trial [2];
  logic [63:0] dabs;
  logic signed [31:0] res [2];

  assign dabs = den[63] ? 64'(-den) : 64'(den);
  assign nmag[0] = num0[63] ? 64'(-num0) : 64'(num0);
  assign nmag[1] = num1[63] ? 64'(-num1) : 64'(num1);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      trial[i] = {rem[i], nlow[i][2]};
      if (ovf[i]) begin
        res[i] = neg[i] ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
        res[i] = neg[i] ? -$signed({1'b0, q[i]}) : $signed({1'b0, q[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 5'(DIV_STEPS);
      end else if (busy) begin
        count <= count - 5'd1;
        if (count == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dmag <= dabs;
      for (int i = 0; i < 2; i++) begin
        rem[i] <= {3'b000, nmag[i][63:3]};
        nlow[i] <= nmag[i][2:0];
        q[i] <= '0;
        ovf[i] <= {3'b000, nmag[i]} >= {dabs, 3'b000};
      end
      neg[0] <= num0[63] ^ den[63];
      neg[1] <= num1[63] ^ den[63];
    end else if (busy) begin
      for (int i = 0; i < 2; i++) begin
        nlow[i] <= {nlow[i][1:0], 1'b0};
        if (trial[i] >= {1'b0, dmag}) begin
          rem[i] <= 64'(trial[i] - {1'b0, dmag});
          q[i] <= {q[i][29:0], 1'b1};
        end else begin
          rem[i] <= trial[i][63:0];
          q[i] <= {q[i][29:0], 1'b0};
        end
      end
    end
  end

  assign quo0 = res[0];
  assign quo1 = res[1];

endmodule

FILE: rtl/ibqm_dp.sv
`timescale 1ns / 1ps
module ibqm_dp import ibqm_pkg::*; (
  input  logic         clk,
  input  ibqm_query_t  query,
  input  logic [31:0]  tolerance,
  input  ibqm_cmd_t    cmd,
  output ibqm_status_t status,
  output logic signed [31:0] param_u,
  output logic signed [31:0] param_v,
  output logic         singular
);

  logic signed [31:0] a0, a1, a2, a3, b0, b1, b2, b3, px, py;
  logic signed [31:0] u, v, uv, rx, ry;
  logic signed [63:0] det, numu, numv, prod, prod_c;
  logic signed [37:0] dx_acc, dy_acc;
  logic [63:0]        res;
  logic signed [31:0] ma, mb, dx, dy, qu, qv;
  logic signed [35:0] term;
  logic signed [33:0] x0, x1, x2, x3, y0, y1, y2, y3;
  logic signed [33:0] sa0, sa1, sa2, sa3, sb0, sb1, sb2, sb3;
  logic               div_done;

  assign x0 = 34'(query.corner0_x);
  assign x1 = 34'(query.corner1_x);
  assign x2 = 34'(query.corner2_x);
  assign x3 = 34'(query.corner3_x);
  assign y0 = 34'(query.corner0_y);
  assign y1 = 34'(query.corner1_y);
  assign y2 = 34'(query.corner2_y);
  assign y3 = 34'(query.corner3_y);
  assign sa0 = x0 + x1 + x2 + x3;
  assign sa1 = -x0 + x1 + x2 - x3;
  assign sa2 = -x0 - x1 + x2 + x3;
  assign sa3 = x0 - x1 + x2 - x3;
  assign sb0 = y0 + y1 + y2 + y3;
  assign sb1 = -y0 + y1 + y2 - y3;
  assign sb2 = -y0 - y1 + y2 + y3;
  assign sb3 = y0 - y1 + y2 - y3;

  assign dx = sat32(dx_acc);
  assign dy = sat32(dy_acc);
  assign term = prod[63:28];

  always_comb begin
    case (cmd.mul_sel)
      MUL_A1_B2: begin ma = a1; mb = b2; end
      MUL_A2_B1: begin ma = a2; mb = b1; end
      MUL_A3_UV: begin ma = a3; mb = uv; end
      MUL_B3_UV: begin ma = b3; mb = uv; end
      MUL_B2_RX: begin ma = b2; mb = rx; end
      MUL_A2_RY: begin ma = a2; mb = ry; end
      MUL_A1_RY: begin ma = a1; mb = ry; end
      MUL_B1_RX: begin ma = b1; mb = rx; end
      MUL_U_V:   begin ma = u;  mb = v;  end
      MUL_A1_U:  begin ma = a1; mb = u;  end
      MUL_B1_U:  begin ma = b1; mb = u;  end
      MUL_A2_V:  begin ma = a2; mb = v;  end
      MUL_B2_V:  begin ma = b2; mb = v;  end
      MUL_DX_DX: begin ma = dx; mb = dx; end
      MUL_DY_DY: begin ma = dy; mb = dy; end
      default:   begin ma = '0; mb = '0; end
    endcase
  end

  assign prod_c = ma * mb;

  ibqm_div u_div (
    .clk  (clk),
    .rst  (cmd.load),
    .start(cmd.div_start),
    .num0 (numu),
    .num1 (numv),
    .den  (det),
    .done (div_done),
    .quo0 (qu),
    .quo1 (qv)
  );

  always_ff @(posedge clk) begin
    prod <= prod_c;
    if (cmd.load) begin
      a0 <= sa0[33:2]; a1 <= sa1[33:2]; a2 <= sa2[33:2]; a3 <= sa3[33:2];
      b0 <= sb0[33:2]; b1 <= sb1[33:2]; b2 <= sb2[33:2]; b3 <= sb3[33:2];
      px <= query.query_x;
      py <= query.query_y;
      u <= '0;
      v <= '0;
      uv <= '0;
    end
    if (div_done) begin
      u <= qu;
      v <= qv;
    end
    case (cmd.wb_sel)
      WB_DET_LD:   det <= prod;
      WB_DET_SUB:  det <= det - prod;
      WB_RX:       rx <= sat32(38'(px) - 38'(a0) - 38'(term));
      WB_RY:       ry <= sat32(38'(py) - 38'(b0) - 38'(term));
      WB_NUMU_LD:  numu <= prod;
      WB_NUMU_SUB: numu <= numu - prod;
      WB_NUMV_LD:  numv <= prod;
      WB_NUMV_SUB: numv <= numv - prod;
      WB_UV: begin
        uv <= sat32(38'(term));
        dx_acc <= 38'(px) - 38'(a0);
        dy_acc <= 38'(py) - 38'(b0);
      end
      WB_DX_SUB:   dx_acc <= dx_acc - 38'(term);
      WB_DY_SUB:   dy_acc <= dy_acc - 38'(term);
      WB_RES_LD:   res <= prod;
      WB_RES_ADD:  res <= res + prod;
      default: ;
    endcase
    if (cmd.out_load) begin
      param_u <= u;
      param_v <= v;
      singular <= (det == 64'sd0);
    end
  end

  assign status.det_zero = (det == 64'sd0);
  assign status.below_tol = res < {32'd0, tolerance};
  assign status.div_done = div_done;

endmodule

FILE: rtl/ibqm_ctrl.sv
`timescale 1ns / 1ps
module ibqm_ctrl import ibqm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  input  logic [7:0]   max_iterations,
  input  ibqm_status_t status,
  output ibqm_cmd_t    cmd,
  output logic         converged,
  output logic [7:0]   iterations_used
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DET    = 6'b000010,
    S_ITER_A = 6'b000100,
    S_DIV    = 6'b001000,
    S_ITER_B = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [3:0] step, step_next;
  logic [7:0] count, count_next;
  logic       conv_flag, conv_flag_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    step_next = step + 4'd1;
    count_next = count;
    conv_flag_next = conv_flag;
    out_valid_next = out_valid && !out_ready;
    cmd = '{load: 1'b0, out_load: 1'b0, div_start: 1'b0,
            mul_sel: MUL_NONE, wb_sel: WB_NONE};
    unique case (state)
      S_IDLE: begin
        step_next = '0;
        if (in_valid) begin
          cmd.load = 1'b1;
          count_next = '0;
          conv_flag_next = 1'b0;
          state_next = S_DET;
        end
      end
      S_DET: begin
        case (step)
          4'd0: cmd.mul_sel = MUL_A1_B2;
          4'd1: begin cmd.mul_sel = MUL_A2_B1; cmd.wb_sel = WB_DET_LD; end
          4'd2: cmd.wb_sel = WB_DET_SUB;
          default: begin
            step_next = '0;
            if (status.det_zero || max_iterations == 8'd0) begin
              state_next = S_FINISH;
            end else begin
              state_next = S_ITER_A;
            end
          end
        endcase
      end
      S_ITER_A: begin
        case (step)
          4'd0: cmd.mul_sel = MUL_A3_UV;
          4'd1: begin cmd.mul_sel = MUL_B3_UV; cmd.wb_sel = WB_RX; end
          4'd2: begin cmd.mul_sel = MUL_B2_RX; cmd.wb_sel = WB_RY; end
          4'd3: begin cmd.mul_sel = MUL_A2_RY; cmd.wb_sel = WB_NUMU_LD; end
          4'd4: begin cmd.mul_sel = MUL_A1_RY; cmd.wb_sel = WB_NUMU_SUB; end
          4'd5: begin cmd.mul_sel = MUL_B1_RX; cmd.wb_sel = WB_NUMV_LD; end
          4'd6: cmd.wb_sel = WB_NUMV_SUB;
          default: begin
            cmd.div_start = 1'b1;
            step_next = '0;
            state_next = S_DIV;
          end
        endcase
      end
      S_DIV: begin
        step_next = '0;
        if (status.div_done) begin
          state_next = S_ITER_B;
        end
      end
      S_ITER_B: begin
        case (step)
          4'd0: cmd.mul_sel = MUL_U_V;
          4'd1: begin cmd.mul_sel = MUL_A1_U; cmd.wb_sel = WB_UV; end
          4'd2: begin cmd.mul_sel = MUL_B1_U; cmd.wb_sel = WB_DX_SUB; end
          4'd3: begin cmd.mul_sel = MUL_A2_V; cmd.wb_sel = WB_DY_SUB; end
          4'd4: begin cmd.mul_sel = MUL_B2_V; cmd.wb_sel = WB_DX_SUB; end
          4'd5: begin cmd.mul_sel = MUL_A3_UV; cmd.wb_sel = WB_DY_SUB; end
          4'd6: begin cmd.mul_sel = MUL_B3_UV; cmd.wb_sel = WB_DX_SUB; end
          4'd7: cmd.wb_sel = WB_DY_SUB;
          4'd8: cmd.mul_sel = MUL_DX_DX;
          4'd9: begin cmd.mul_sel = MUL_DY_DY; cmd.wb_sel = WB_RES_LD; end
          4'd10: cmd.wb_sel = WB_RES_ADD;
          default: begin
            step_next = '0;
            count_next = count + 8'd1;
            if (status.below_tol) begin
              conv_flag_next = 1'b1;
              state_next = S_FINISH;
            end else if (count + 8'd1 == max_iterations) begin
              state_next = S_FINISH;
            end else begin
              state_next = S_ITER_A;
            end
          end
        endcase
      end
      S_FINISH: begin
        step_next = '0;
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      count <= '0;
      conv_flag <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step <= step_next;
      count <= count_next;
      conv_flag <= conv_flag_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      converged <= conv_flag;
      iterations_used <= count;
    end
  end

endmodule

FILE: rtl/inverse_bilinear_quad_map.sv
`timescale 1ns / 1ps
// The determinant comes first; each iteration then runs setup, the divider and the residual.
// Throughput: one query at a time, so the iteration count sets the rate; the serial
// two-lane divider (one quotient bit per cycle) dominates each iteration.
// A finished result waits in an output register while the next query is accepted.
// Reset (rst, synchronous, active high) clears the controller and restores
// max_iterations to 100 and residual_tolerance to 1.
module inverse_bilinear_quad_map import ibqm_pkg::*; (
  input logic           clk,
  input logic           rst,
  ibqm_query_if.sink    query,
  ibqm_result_if.source result,
  ibqm_cfg_if.sink      cfg
);

  // Configuration registers. Writes are accepted every cycle; an index outside
  // the register list is ignored.
  logic [7:0]   max_iterations;
  logic [31:0]  residual_tolerance;
  ibqm_cmd_t    cmd;
  ibqm_status_t status;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= MAX_ITER_RESET;
      residual_tolerance <= TOLERANCE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_MAX_ITER:  max_iterations <= cfg.wdata[7:0];
        CFG_TOLERANCE: residual_tolerance <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // The controller sequences the shared multiplier and the divider through the
  // determinant; unless it or the limit is zero, it repeats the fixed-point update
  // until the squared residual drops below the tolerance or the limit is reached.
  ibqm_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (query.valid),
    .in_ready       (query.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .max_iterations (max_iterations),
    .status         (status),
    .cmd            (cmd),
    .converged      (result.data.converged),
    .iterations_used(result.data.iterations_used)
  );

  // The datapath holds the bilinear coefficients, the iterate and the residual.
  ibqm_dp u_dp (
    .clk      (clk),
    .query    (query.data),
    .tolerance(residual_tolerance),
    .cmd      (cmd),
    .status   (status),
    .param_u  (result.data.param_u),
    .param_v  (result.data.param_v),
    .singular (result.data.singular)
  );

  // Only one query is in flight: after a transaction the input closes.
  assert property (@(posedge clk) disable iff (rst)
    query.valid && query.ready |=> !query.ready)
    else $error("query accepted while busy");

  // A singular quad never iterates and reports a zero parameter.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.singular |->
      result.data.param_u == 32'sd0 && result.data.param_v == 32'sd0 &&
      !result.data.converged && result.data.iterations_used == 8'd0)
    else $error("singular result not cleared");

  // Convergence needs at least one iteration.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.converged |-> result.data.iterations_used != 8'd0)
    else $error("converged without iterating");

  // A non-converged iterating query ran to the limit.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.data.converged && result.data.iterations_used != 8'd0 |->
      result.data.iterations_used == max_iterations)
    else $error("stopped before the iteration limit");

endmodule

FILE: bench/inverse_bilinear_quad_map_tb.sv
`timescale 1ns / 1ps
// Bench for the inverse bilinear quad map. Queries are predicted when their
// transaction is accepted, and each result transaction is checked field by
// field against the oldest prediction still waiting.
module inverse_bilinear_quad_map_tb;
  import ibqm_pkg::*;

  logic clk;
  logic rst;

  ibqm_query_if  q_if ();
  ibqm_result_if r_if ();
  ibqm_cfg_if    c_if ();

  inverse_bilinear_quad_map DUT (
    .clk   (clk),
    .rst   (rst),
    .query (q_if),
    .result(r_if),
    .cfg   (c_if)
  );

  // A single query can run 255 iterations, so the watchdog allows several
  // times the length of such a query with no transaction at all.
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int DRAIN_CYCLES = 20;

  // Our own copy of the two registers, updated when a write is accepted.
  logic [7:0]  iter_limit;
  logic [31:0] tolerance;

  ibqm_result_t expected_results[$];
  int           error_count;
  bit           quiet;
  int           idle_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------
  // Predictor. Values are 64-bit, signed but for the residual and the divide
  // magnitudes; an arithmetic right shift gives the floor division by a power of two.
  // ---------------------------------------------------------------------
  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (x < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return x;
  endfunction

  // num * 2^28 / den rounded toward zero, saturated to Q3.28.
  function automatic longint q28_divide(longint num, longint den);
    longint unsigned n, d, rem, quo;
    bit neg;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    neg = (num < 0) != (den < 0);
    quo = n / d;
    rem = n % d;
    if (quo >= 8) begin
      return neg ? -64'sd2147483648 : 64'sd2147483647;
    end
    for (int k = 0; k < PARAM_FRAC; k++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= d) begin
        rem = rem - d;
        quo = quo | 1;
      end
    end
    return neg ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic ibqm_result_t predict_map(ibqm_query_t q);
    longint x0, x1, x2, x3, y0, y1, y2, y3, px, py;
    longint a0, a1, a2, a3, b0, b1, b2, b3;
    longint det, u, v, uv, rx, ry, dx, dy;
    longint unsigned resid;
    ibqm_result_t r;
    x0 = q.corner0_x; y0 = q.corner0_y;
    x1 = q.corner1_x; y1 = q.corner1_y;
    x2 = q.corner2_x; y2 = q.corner2_y;
    x3 = q.corner3_x; y3 = q.corner3_y;
    px = q.query_x;   py = q.query_y;
    a0 = (x0 + x1 + x2 + x3) >>> 2;
    a1 = (-x0 + x1 + x2 - x3) >>> 2;
    a2 = (-x0 - x1 + x2 + x3) >>> 2;
    a3 = (x0 - x1 + x2 - x3) >>> 2;
    b0 = (y0 + y1 + y2 + y3) >>> 2;
    b1 = (-y0 + y1 + y2 - y3) >>> 2;
    b2 = (-y0 - y1 + y2 + y3) >>> 2;
    b3 = (y0 - y1 + y2 - y3) >>> 2;
    r = '0;
    u = 0;
    v = 0;
    det = a1 * b2 - a2 * b1;
    if (det == 0) begin
      r.singular = 1'b1;
    end else begin
      for (int it = 0; it < iter_limit; it++) begin
        uv = clip32((u * v) >>> PARAM_FRAC);
        rx = clip32(px - a0 - ((a3 * uv) >>> PARAM_FRAC));
        ry = clip32(py - b0 - ((b3 * uv) >>> PARAM_FRAC));
        u = q28_divide(b2 * rx - a2 * ry, det);
        v = q28_divide(a1 * ry - b1 * rx, det);
        uv = clip32((u * v) >>> PARAM_FRAC);
        dx = clip32(px - a0 - (((a1 * u) >>> PARAM_FRAC) + ((a2 * v) >>> PARAM_FRAC)
                               + ((a3 * uv) >>> PARAM_FRAC)));
        dy = clip32(py - b0 - (((b1 * u) >>> PARAM_FRAC) + ((b2 * v) >>> PARAM_FRAC)
                               + ((b3 * uv) >>> PARAM_FRAC)));
        resid = longint'(dx * dx) + longint'(dy * dy);
        r.iterations_used = 8'(it + 1);
        if (resid < tolerance) begin
          r.converged = 1'b1;
          break;
        end
      end
    end
    r.param_u = u[31:0];
    r.param_v = v[31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Shared drivers.
  // ---------------------------------------------------------------------
  task automatic report(string what, longint got, longint want);
    error_count++;
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Sends one query. The valid line is lowered only when a gap is inserted,
  // so back-to-back transactions never see valid dropped and raised in the
  // same step.
  task automatic send_query(ibqm_query_t item);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    @(negedge clk);
    if (gap > 0) begin
      q_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    q_if.data = item;
    q_if.valid = 1'b1;
    do @(posedge clk); while (!q_if.ready);
    expected_results.push_back(predict_map(item));
  endtask

  // Waits until every predicted result has been checked, then lets the block
  // settle. Every query yields a result, so a short pause is enough.
  task automatic wait_drained();
    @(negedge clk);
    q_if.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only while the block is drained.
  task automatic write_reg(logic [7:0] idx, logic [31:0] value);
    @(negedge clk);
    c_if.index = idx;
    c_if.wdata = value;
    c_if.valid = 1'b1;
    do @(posedge clk); while (!c_if.ready);
    if (idx == CFG_MAX_ITER) begin
      iter_limit = value[7:0];
    end else if (idx == CFG_TOLERANCE) begin
      tolerance = value;
    end
    @(negedge clk);
    c_if.valid = 1'b0;
  endtask

  task automatic configure(logic [7:0] iters, logic [31:0] tol);
    wait_drained();
    write_reg(CFG_MAX_ITER, {24'd0, iters});
    write_reg(CFG_TOLERANCE, tol);
  endtask

  // ---------------------------------------------------------------------
  // Stimulus shapes.
  // ---------------------------------------------------------------------
  function automatic ibqm_query_t make_quad(logic signed [31:0] x0, logic signed [31:0] y0,
                                            logic signed [31:0] x1, logic signed [31:0] y1,
                                            logic signed [31:0] x2, logic signed [31:0] y2,
                                            logic signed [31:0] x3, logic signed [31:0] y3,
                                            logic signed [31:0] px, logic signed [31:0] py);
    ibqm_query_t q;
    q.corner0_x = x0; q.corner0_y = y0;
    q.corner1_x = x1; q.corner1_y = y1;
    q.corner2_x = x2; q.corner2_y = y2;
    q.corner3_x = x3; q.corner3_y = y3;
    q.query_x = px;   q.query_y = py;
    return q;
  endfunction

  // Random fields over the whole range, for noise.
  function automatic ibqm_query_t noise_query();
    ibqm_query_t q;
    for (int k = 0; k < $bits(q) / 32; k++) begin
      q[k*32 +: 32] = $urandom();
    end
    return q;
  endfunction

  // A convex, roughly square quad in counterclockwise order with the query
  // point near or inside it. These are the cases that converge.
  function automatic ibqm_query_t shaped_query();
    int cx, cy, h, jit;
    int j[8];
    cx = $signed($urandom_range(0, 32'h3FFFFF)) - 32'sh200000;
    cy = $signed($urandom_range(0, 32'h3FFFFF)) - 32'sh200000;
    h = $urandom_range(1 << 8, 1 << 22);
    jit = h / 4;
    foreach (j[k]) j[k] = $signed($urandom_range(0, 2 * jit)) - jit;
    return make_quad(cx - h + j[0], cy - h + j[1], cx + h + j[2], cy - h + j[3],
                     cx + h + j[4], cy + h + j[5], cx - h + j[6], cy + h + j[7],
                     cx + $signed($urandom_range(0, 3 * h)) - 3 * h / 2,
                     cy + $signed($urandom_range(0, 3 * h)) - 3 * h / 2);
  endfunction

  // Corners on one line or coincident, so the Jacobian has no inverse.
  function automatic ibqm_query_t flat_query();
    int bx, dx;
    bx = $urandom();
    dx = $urandom_range(0, 1 << 16);
    return make_quad(bx, bx, bx + dx, bx + dx, bx + 2 * dx, bx + 2 * dx,
                     bx + 3 * dx, bx + 3 * dx, $urandom(), $urandom());
  endfunction

  function automatic ibqm_query_t random_query();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return shaped_query();
    if (pick < 9) return noise_query();
    return flat_query();
  endfunction

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------
  localparam logic signed [31:0] MAXC = 32'sh7fffffff;
  localparam logic signed [31:0] MINC = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  // Field extremes, the singular Jacobian, saturated quotients and the
  // plain unit square, all under the reset settings.
  task automatic test_directed_queries();
    send_query(make_quad(0, 0, ONE, 0, ONE, ONE, 0, ONE, ONE / 2, ONE / 2));
    send_query(make_quad(0, 0, ONE, 0, ONE, ONE, 0, ONE, 0, 0));
    send_query(make_quad(0, 0, ONE, 0, ONE, ONE, 0, ONE, ONE, ONE));
    send_query(make_quad(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_query(make_quad(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
    send_query(make_quad(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC));
    send_query(make_quad(MINC, MINC, MAXC, MINC, MAXC, MAXC, MINC, MAXC, 0, 0));
    send_query(make_quad(MINC, MINC, MAXC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC));
    send_query(make_quad(MAXC, MINC, MINC, MAXC, MAXC, MINC, MINC, MAXC, MINC, MAXC));
    send_query(make_quad(0, 0, 1, 0, 1, 1, 0, 1, MAXC, MINC));
    send_query(make_quad(0, 0, 4, 0, 4, 4, 0, 4, MINC, MAXC));
    send_query(make_quad(0, 0, ONE, ONE, 2 * ONE, 2 * ONE, 3 * ONE, 3 * ONE, 0, 0));
    send_query(make_quad(0, 0, 2 * ONE, 0, ONE, ONE, 0, 3 * ONE, ONE, ONE / 3));
    send_query(make_quad(-ONE, -ONE, ONE, -ONE, ONE, ONE, -ONE, ONE, 5 * ONE, -7 * ONE));
    send_query(make_quad(0, 0, ONE, 0, 0, ONE, ONE, ONE, ONE / 2, ONE / 4));
    send_query(make_quad(MAXC, 0, 0, MAXC, MINC, 0, 0, MINC, 0, 0));
    send_query(make_quad(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
  endtask

  // Zero and one iteration, the largest limit with a tolerance nothing
  // meets, and the widest tolerance.
  task automatic test_register_extremes();
    configure(8'd0, 32'd1);
    repeat (3) send_query(shaped_query());
    send_query(flat_query());
    configure(8'd1, 32'hffffffff);
    repeat (6) send_query(random_query());
    configure(8'd255, 32'd0);
    repeat (2) send_query(shaped_query());
    configure(8'd255, 32'hffffffff);
    repeat (3) send_query(shaped_query());
    configure(8'd255, 32'h00010000);
    repeat (3) send_query(shaped_query());
  endtask

  // Mostly well-formed quads in phases of varying settings. Iteration limits
  // stay small so the run length is set by the item count.
  task automatic test_random_queries(int phases, int per_phase);
    logic [31:0] tol;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 3))
        0: tol = 32'd1;
        1: tol = $urandom_range(1, 1 << 20);
        2: tol = $urandom();
        default: tol = 32'hffffffff >> $urandom_range(0, 31);
      endcase
      configure(8'($urandom_range(1, 7)), tol);
      repeat (per_phase) send_query(random_query());
    end
  endtask

  // Back-to-back transactions on both sides, no idling at all.
  task automatic test_full_rate();
    quiet = 1'b1;
    configure(8'd3, 32'h00100000);
    repeat (150) send_query(random_query());
    wait_drained();
  endtask

  // ---------------------------------------------------------------------
  // Result checking, receiver stalls and the watchdog.
  // ---------------------------------------------------------------------
  int stall_left;

  always @(negedge clk) begin
    if (rst) begin
      r_if.ready = 1'b1;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      r_if.ready = 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 11);
      r_if.ready = 1'b0;
    end else begin
      r_if.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    ibqm_result_t want;
    ibqm_result_t got;
    if (!rst && r_if.valid && r_if.ready) begin
      got = r_if.data;
      if (expected_results.size() == 0) begin
        report("unexpected result", got.param_u, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.param_u !== want.param_u) report("param_u", got.param_u, want.param_u);
        if (got.param_v !== want.param_v) report("param_v", got.param_v, want.param_v);
        if (got.converged !== want.converged) begin
          report("converged", got.converged, want.converged);
        end
        if (got.singular !== want.singular) report("singular", got.singular, want.singular);
        if (got.iterations_used !== want.iterations_used) begin
          report("iterations_used", got.iterations_used, want.iterations_used);
        end
      end
    end
  end

  // Counts cycles in which no transaction of any kind takes place.
  always @(posedge clk) begin
    if (rst || (q_if.valid && q_if.ready) || (r_if.valid && r_if.ready)
        || (c_if.valid && c_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    quiet = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    iter_limit = MAX_ITER_RESET;
    tolerance = TOLERANCE_RESET;
    q_if.valid = 1'b0;
    q_if.data = '0;
    c_if.valid = 1'b0;
    c_if.index = CFG_MAX_ITER;
    c_if.wdata = '0;
    r_if.ready = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_queries();
    test_register_extremes();
    test_random_queries(25, 50);
    test_full_rate();

    if (expected_results.size() != 0) begin
      report("results never delivered", expected_results.size(), 0);
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ibqm_pkg.sv
rtl/ibqm_if.sv
rtl/ibqm_div.sv
rtl/ibqm_dp.sv
rtl/ibqm_ctrl.sv
rtl/inverse_bilinear_quad_map.sv
bench/inverse_bilinear_quad_map_tb.sv
